/* src/accumulator_cpu_with_write_protect_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator processor
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_WITH_WRITE_PROTECT_MACROS_SVH
`define ACCUMULATOR_CPU_WITH_WRITE_PROTECT_MACROS_SVH

// Same-cycle implication
`define ACP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("accumulator processor: same-cycle check failed");

// Next-cycle implication
`define ACP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("accumulator processor: next-cycle check failed");

`endif

/* src/acp_pkg.sv */
// ----------------------------------------------------------------------------
// acp_pkg
// Widths, constants, opcodes and shared types of the accumulator processor.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int MEM_DEPTH     = 4096;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int DATA_W        = 8;
    localparam int WORD_W        = 16;
    localparam int PROTECT_SLOTS = 16;
    localparam int PIDX_W        = (PROTECT_SLOTS > 1) ? $clog2(PROTECT_SLOTS) : 1;

    localparam logic [ADDR_W-1:0] RESTART_PC   = 12'h100;
    localparam logic [ADDR_W-1:0] CLEAR_LAST   = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [WORD_W-1:0] PRINT_WORD   = 16'h1337;
    localparam logic [WORD_W-1:0] RESTART_WORD = 16'hBEEF;
    localparam logic [WORD_W-1:0] NOP_WORD     = 16'hEEEE;
    localparam logic [DATA_W-1:0] RESTART_ACC  = 8'h42;
    localparam logic [DATA_W-1:0] XOR_KEY      = 8'h42;
    localparam logic [DATA_W-1:0] ACC_ONES     = 8'hFF;
    localparam logic [DATA_W-1:0] ACC_ONE      = 8'h01;

    // Sub-operations of the immediate group
    localparam logic [3:0] SUB_ADD = 4'h0;
    localparam logic [3:0] SUB_LDI = 4'h1;
    localparam logic [3:0] SUB_XOR = 4'h2;
    localparam logic [3:0] SUB_OR  = 4'h3;
    localparam logic [3:0] SUB_AND = 4'h4;

    typedef enum logic [3:0] {
        OP_IMM     = 4'h0,
        OP_PRINT   = 4'h1,
        OP_JMP     = 4'h2,
        OP_JZ      = 4'h3,
        OP_JONE    = 4'h4,
        OP_JFF     = 4'h5,
        OP_CMPI    = 4'h6,
        OP_CMPM    = 4'h7,
        OP_LDM     = 4'h8,
        OP_PADD    = 4'h9,
        OP_PDEL    = 4'hA,
        OP_RESTART = 4'hB,
        OP_XORK    = 4'hC,
        OP_XORA    = 4'hD,
        OP_NOP     = 4'hE,
        OP_ST      = 4'hF
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              add;
        logic              remove;
        logic [ADDR_W-1:0] addr;
    } prot_cmd_t;

    typedef struct packed {
        logic hit;
        logic full;
    } prot_stat_t;

    function automatic logic [DATA_W-1:0] compare_code(input logic [DATA_W-1:0] x,
                                                       input logic [DATA_W-1:0] y);
        logic [DATA_W-1:0] r;
        if (x == y)
            r = '0;
        else if (x < y)
            r = ACC_ONE;
        else
            r = ACC_ONES;
        return r;
    endfunction

endpackage

/* src/accumulator_cpu_with_write_protect.sv */
// ----------------------------------------------------------------------------
// accumulator_cpu_with_write_protect
// Execute item: accepted in IDLE, then FETCH_HI, FETCH_LO and EXEC, result
// strobe on the cycle after (hi byte, lo byte, operand read, execute and
// write-back, all through the one memory port). Load item: written in the
// accepting cycle, result strobe on the next; a new item may start while a
// result is shown. Reset: async, active low; then a clearing pass of all main
// memory with busy high. The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_with_write_protect_macros.svh"

module accumulator_cpu_with_write_protect (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       func,
    input  logic [acp_pkg::ADDR_W-1:0] load_addr,
    input  logic [acp_pkg::DATA_W-1:0] load_data,
    output logic                       done,
    output logic [acp_pkg::DATA_W-1:0] acc,
    output logic [acp_pkg::ADDR_W-1:0] pc,
    output logic [acp_pkg::WORD_W-1:0] instruction,
    output logic                       print_valid,
    output logic                       protect_overflow
);

    acp_pkg::state_t            state_reg, state_next;
    logic [acp_pkg::ADDR_W-1:0] clr_reg, clr_next;
    logic [acp_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic [acp_pkg::ADDR_W-1:0] pc_reg, pc_next;
    logic [acp_pkg::DATA_W-1:0] hi_reg, hi_next;
    logic [acp_pkg::WORD_W-1:0] word_reg, word_next;
    logic [acp_pkg::WORD_W-1:0] instr_reg, instr_next;
    logic                       print_reg, print_next;
    logic                       ovf_reg, ovf_next;
    logic                       done_reg, done_next;

    logic [acp_pkg::ADDR_W-1:0] mem_addr;
    logic                       mem_we;
    logic [acp_pkg::DATA_W-1:0] mem_wdata;
    logic [acp_pkg::DATA_W-1:0] mem_rdata;

    acp_pkg::prot_cmd_t         prot_cmd;
    acp_pkg::prot_stat_t        prot_stat;
    logic [acp_pkg::ADDR_W-1:0] prot_search;

    logic [acp_pkg::ADDR_W-1:0] op_a;
    logic [acp_pkg::DATA_W-1:0] op_k;
    logic [acp_pkg::DATA_W-1:0] acc_dec;
    logic [acp_pkg::ADDR_W-1:0] pc_step;

    acp_mem u_mem (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    acp_protect u_protect (
        .clk         (clk),
        .rst_n       (rst_n),
        .search_addr (prot_search),
        .cmd         (prot_cmd),
        .stat        (prot_stat)
    );

    assign op_a    = word_reg[acp_pkg::ADDR_W-1:0];
    assign op_k    = word_reg[acp_pkg::DATA_W-1:0];
    assign acc_dec = acc_reg - acp_pkg::DATA_W'(1);
    assign pc_step = pc_reg + acp_pkg::ADDR_W'(2);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        acc_next    = acc_reg;
        pc_next     = pc_reg;
        hi_next     = hi_reg;
        word_next   = word_reg;
        instr_next  = instr_reg;
        print_next  = print_reg;
        ovf_next    = ovf_reg;
        done_next   = 1'b0;
        mem_addr    = pc_reg;
        mem_we      = 1'b0;
        mem_wdata   = acc_reg;
        prot_search = op_a;
        prot_cmd    = '{add: 1'b0, remove: 1'b0, addr: op_a};

        case (state_reg)
            acp_pkg::ST_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
                clr_next  = clr_reg + acp_pkg::ADDR_W'(1);
                if (clr_reg == acp_pkg::CLEAR_LAST)
                begin
                    state_next = acp_pkg::ST_IDLE;
                end
            end

            acp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!func)
                    begin
                        // load beat: write now, report next cycle
                        mem_addr   = load_addr;
                        mem_we     = 1'b1;
                        mem_wdata  = load_data;
                        instr_next = '0;
                        print_next = 1'b0;
                        ovf_next   = 1'b0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        mem_addr   = pc_reg;
                        state_next = acp_pkg::ST_FETCH_HI;
                    end
                end
            end

            acp_pkg::ST_FETCH_HI:
            begin
                hi_next    = mem_rdata;
                mem_addr   = pc_reg + acp_pkg::ADDR_W'(1);
                state_next = acp_pkg::ST_FETCH_LO;
            end

            acp_pkg::ST_FETCH_LO:
            begin
                // operand read and protect search both run on the fresh address
                word_next   = {hi_reg, mem_rdata};
                mem_addr    = {hi_reg[acp_pkg::ADDR_W-acp_pkg::DATA_W-1:0], mem_rdata};
                prot_search = mem_addr;
                state_next  = acp_pkg::ST_EXEC;
            end

            acp_pkg::ST_EXEC:
            begin
                mem_addr   = op_a;
                pc_next    = pc_step;
                instr_next = word_reg;
                print_next = 1'b0;
                ovf_next   = 1'b0;
                done_next  = 1'b1;
                state_next = acp_pkg::ST_IDLE;

                case (acp_pkg::op_t'(word_reg[acp_pkg::WORD_W-1:acp_pkg::WORD_W-4]))
                    acp_pkg::OP_IMM:
                    begin
                        case (word_reg[11:8])
                            acp_pkg::SUB_ADD: acc_next = acc_reg + op_k;
                            acp_pkg::SUB_LDI: acc_next = op_k;
                            acp_pkg::SUB_XOR: acc_next = acc_reg ^ op_k;
                            acp_pkg::SUB_OR:  acc_next = acc_reg | op_k;
                            acp_pkg::SUB_AND: acc_next = acc_reg & op_k;
                            default:          acc_next = acc_dec;
                        endcase
                    end
                    acp_pkg::OP_PRINT:
                    begin
                        if (word_reg == acp_pkg::PRINT_WORD)
                            print_next = 1'b1;
                        else
                            acc_next = acc_dec;
                    end
                    acp_pkg::OP_JMP:
                    begin
                        pc_next = op_a;
                    end
                    acp_pkg::OP_JZ:
                    begin
                        if (acc_reg == '0)
                            pc_next = op_a;
                    end
                    acp_pkg::OP_JONE:
                    begin
                        if (acc_reg == acp_pkg::ACC_ONE)
                            pc_next = op_a;
                    end
                    acp_pkg::OP_JFF:
                    begin
                        if (acc_reg == acp_pkg::ACC_ONES)
                            pc_next = op_a;
                    end
                    acp_pkg::OP_CMPI:
                    begin
                        acc_next = acp_pkg::compare_code(acc_reg, op_k);
                    end
                    acp_pkg::OP_CMPM:
                    begin
                        acc_next = acp_pkg::compare_code(acc_reg, mem_rdata);
                    end
                    acp_pkg::OP_LDM:
                    begin
                        acc_next = mem_rdata;
                    end
                    acp_pkg::OP_PADD:
                    begin
                        prot_cmd.add = 1'b1;
                        ovf_next     = !prot_stat.hit && prot_stat.full;
                    end
                    acp_pkg::OP_PDEL:
                    begin
                        prot_cmd.remove = 1'b1;
                    end
                    acp_pkg::OP_RESTART:
                    begin
                        if (word_reg == acp_pkg::RESTART_WORD)
                        begin
                            pc_next  = acp_pkg::RESTART_PC;
                            acc_next = acp_pkg::RESTART_ACC;
                        end
                        else
                        begin
                            acc_next = acc_dec;
                        end
                    end
                    acp_pkg::OP_XORK:
                    begin
                        mem_we    = !prot_stat.hit;
                        mem_wdata = mem_rdata ^ acp_pkg::XOR_KEY;
                    end
                    acp_pkg::OP_XORA:
                    begin
                        mem_we    = !prot_stat.hit;
                        mem_wdata = mem_rdata ^ acc_reg;
                    end
                    acp_pkg::OP_NOP:
                    begin
                        if (word_reg != acp_pkg::NOP_WORD)
                            acc_next = acc_dec;
                    end
                    acp_pkg::OP_ST:
                    begin
                        mem_we    = !prot_stat.hit;
                        mem_wdata = acc_reg;
                    end
                    default:
                    begin
                        acc_next = acc_dec;
                    end
                endcase
            end

            default:
            begin
                state_next = acp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acp_pkg::ST_CLEAR;
            clr_reg   <= '0;
            acc_reg   <= '0;
            pc_reg    <= acp_pkg::RESTART_PC;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        word_reg  <= word_next;
        instr_reg <= instr_next;
        print_reg <= print_next;
        ovf_reg   <= ovf_next;
    end

    assign busy             = (state_reg != acp_pkg::ST_IDLE);
    assign done             = done_reg;
    assign acc              = acc_reg;
    assign pc               = pc_reg;
    assign instruction      = instr_reg;
    assign print_valid      = print_reg;
    assign protect_overflow = ovf_reg;

    `ACP_ASSERT_NEXT(a_accept_moves_on, start && !busy, busy || done)
    `ACP_ASSERT_NOW(a_done_when_idle, done, !busy)
    `ACP_ASSERT_NOW(a_print_word, done && print_valid, instruction == acp_pkg::PRINT_WORD)
    `ACP_ASSERT_NOW(a_overflow_on_add, done && protect_overflow, instruction[15:12] == acp_pkg::OP_PADD)

endmodule

/* src/acp_mem.sv */
// ----------------------------------------------------------------------------
// acp_mem
// Single-port main memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module acp_mem (
    input  logic                      clk,
    input  logic [acp_pkg::ADDR_W-1:0] addr,
    input  logic                      we,
    input  logic [acp_pkg::DATA_W-1:0] wdata,
    output logic [acp_pkg::DATA_W-1:0] rdata
);

    logic [acp_pkg::DATA_W-1:0] mem [acp_pkg::MEM_DEPTH];
    logic [acp_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/acp_protect.sv */
// ----------------------------------------------------------------------------
// acp_protect
// Write-protect address set: registered parallel search, lowest-free insert.
// ----------------------------------------------------------------------------
module acp_protect (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [acp_pkg::ADDR_W-1:0] search_addr,
    input  acp_pkg::prot_cmd_t         cmd,
    output acp_pkg::prot_stat_t        stat
);

    localparam int N = acp_pkg::PROTECT_SLOTS;

    logic [acp_pkg::ADDR_W-1:0] addr_reg [N];
    logic [N-1:0]               valid_reg;
    logic [N-1:0]               valid_next;
    logic [N-1:0]               match_reg;
    logic [N-1:0]               match_next;
    logic                       full_reg;
    logic [acp_pkg::PIDX_W-1:0] free_reg;
    logic [acp_pkg::PIDX_W-1:0] free_next;
    logic                       do_add;

    always_comb
    begin
        match_next = '0;
        free_next  = '0;
        for (int i = 0; i < N; i++)
        begin
            match_next[i] = valid_reg[i] && (addr_reg[i] == search_addr);
        end
        // lowest free slot wins: scan from the top down
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_next = acp_pkg::PIDX_W'(i);
            end
        end
    end

    assign do_add = cmd.add && !(|match_reg) && !full_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.remove)
        begin
            valid_next = valid_reg & ~match_reg;
        end
        if (do_add)
        begin
            valid_next[free_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            match_reg <= '0;
            full_reg  <= 1'b0;
            free_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            full_reg  <= &valid_reg;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            addr_reg[free_reg] <= cmd.addr;
        end
    end

    assign stat.hit  = |match_reg;
    assign stat.full = full_reg;

endmodule

/* tb/accumulator_cpu_with_write_protect_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accumulator_cpu_with_write_protect_tb
// Drives byte loads and instruction steps into the accumulator processor and
// checks every result beat against a cycle-free model of the machine. Most
// random steps first write an instruction at the model's program counter,
// then execute it. The operand addresses come mostly from a small hot set, so
// the write-protect set fills, overflows and guards stores.
// ----------------------------------------------------------------------------
module accumulator_cpu_with_write_protect_tb;

    import acp_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int HOT_COUNT   = 20;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] instruction;
        logic              printed;
        logic              overflow;
    } cpu_result_t;

    // Model of the machine plus the queue of results still to come
    class cpu_scoreboard;
        logic [DATA_W-1:0] acc_q;
        logic [ADDR_W-1:0] pc_q;
        logic [DATA_W-1:0] mem [MEM_DEPTH];
        logic [ADDR_W-1:0] guard_addr [PROTECT_SLOTS];
        bit                guard_valid [PROTECT_SLOTS];
        cpu_result_t       awaited_q [$];
        int                failures;

        function new();
            acc_q    = '0;
            pc_q     = RESTART_PC;
            failures = 0;
            foreach (mem[i])
                mem[i] = '0;
            foreach (guard_valid[i])
            begin
                guard_valid[i] = 1'b0;
                guard_addr[i]  = '0;
            end
        endfunction

        function bit is_guarded(logic [ADDR_W-1:0] a);
            bit hit;
            hit = 1'b0;
            foreach (guard_valid[i])
                if (guard_valid[i] && guard_addr[i] == a)
                    hit = 1'b1;
            return hit;
        endfunction

        function logic [DATA_W-1:0] order_code(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y);
            if (x == y)
                return '0;
            return (x < y) ? ACC_ONE : ACC_ONES;
        endfunction

        function void note_item(bit f, logic [ADDR_W-1:0] la, logic [DATA_W-1:0] ld);
            cpu_result_t       r;
            logic [WORD_W-1:0] w;
            logic [ADDR_W-1:0] a;
            logic [ADDR_W-1:0] nxt;
            logic [ADDR_W-1:0] lo_addr;
            logic [DATA_W-1:0] k;
            int                slot;
            r = '0;
            if (!f)
            begin
                mem[la] = ld;
            end
            else
            begin
                lo_addr = pc_q + 12'd1;
                w       = {mem[pc_q], mem[lo_addr]};
                a       = w[ADDR_W-1:0];
                k       = w[DATA_W-1:0];
                nxt     = pc_q + 12'd2;
                case (op_t'(w[15:12]))
                    OP_IMM:
                        case (w[11:8])
                            SUB_ADD: acc_q = acc_q + k;
                            SUB_LDI: acc_q = k;
                            SUB_XOR: acc_q = acc_q ^ k;
                            SUB_OR:  acc_q = acc_q | k;
                            SUB_AND: acc_q = acc_q & k;
                            default: acc_q = acc_q - 8'd1;
                        endcase
                    OP_PRINT:
                        if (w == PRINT_WORD)
                            r.printed = 1'b1;
                        else
                            acc_q = acc_q - 8'd1;
                    OP_JMP:  nxt = a;
                    OP_JZ:   if (acc_q == '0) nxt = a;
                    OP_JONE: if (acc_q == ACC_ONE) nxt = a;
                    OP_JFF:  if (acc_q == ACC_ONES) nxt = a;
                    OP_CMPI: acc_q = order_code(acc_q, k);
                    OP_CMPM: acc_q = order_code(acc_q, mem[a]);
                    OP_LDM:  acc_q = mem[a];
                    OP_PADD:
                        if (!is_guarded(a))
                        begin
                            // scan downwards so the lowest free slot wins
                            slot = -1;
                            for (int i = PROTECT_SLOTS - 1; i >= 0; i--)
                                if (!guard_valid[i])
                                    slot = i;
                            if (slot < 0)
                                r.overflow = 1'b1;
                            else
                            begin
                                guard_addr[slot]  = a;
                                guard_valid[slot] = 1'b1;
                            end
                        end
                    OP_PDEL:
                        foreach (guard_valid[i])
                            if (guard_valid[i] && guard_addr[i] == a)
                                guard_valid[i] = 1'b0;
                    OP_RESTART:
                        if (w == RESTART_WORD)
                        begin
                            nxt   = RESTART_PC;
                            acc_q = RESTART_ACC;
                        end
                        else
                            acc_q = acc_q - 8'd1;
                    OP_XORK: if (!is_guarded(a)) mem[a] = mem[a] ^ XOR_KEY;
                    OP_XORA: if (!is_guarded(a)) mem[a] = mem[a] ^ acc_q;
                    OP_NOP:  if (w != NOP_WORD) acc_q = acc_q - 8'd1;
                    OP_ST:   if (!is_guarded(a)) mem[a] = acc_q;
                endcase
                pc_q          = nxt;
                r.instruction = w;
            end
            r.acc = acc_q;
            r.pc  = pc_q;
            awaited_q = {awaited_q, r};
        endfunction

        function void check_result(cpu_result_t got);
            cpu_result_t want;
            if (awaited_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result with nothing awaited: acc=%02h pc=%03h instr=%04h",
                             $realtime, got.acc, got.pc, got.instruction);
                return;
            end
            want = awaited_q.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $write("[%0t] mismatch  acc %02h/%02h  pc %03h/%03h",
                           $realtime, want.acc, got.acc, want.pc, got.pc);
                    $display("  instr %04h/%04h  print %0b/%0b  ovf %0b/%0b  (expected/actual)",
                             want.instruction, got.instruction, want.printed, got.printed,
                             want.overflow, got.overflow);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              func = 1'b0;
    logic [ADDR_W-1:0] load_addr = '0;
    logic [DATA_W-1:0] load_data = '0;
    logic              done;
    logic [DATA_W-1:0] acc;
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] instruction;
    logic              print_valid;
    logic              protect_overflow;

    cpu_scoreboard     sb;
    int                sent;
    int                idle_pct;
    logic [ADDR_W-1:0] hot_addr [HOT_COUNT];

    accumulator_cpu_with_write_protect dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .load_addr        (load_addr),
        .load_data        (load_data),
        .done             (done),
        .acc              (acc),
        .pc               (pc),
        .instruction      (instruction),
        .print_valid      (print_valid),
        .protect_overflow (protect_overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results cannot be held off: take every strobed beat
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(cpu_result_t'({acc, pc, instruction, print_valid, protect_overflow}));
    end

    task automatic send_item(bit f, logic [ADDR_W-1:0] la, logic [DATA_W-1:0] ld);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            // drop start and scribble on the fields while idle
            start     <= 1'b0;
            func      <= 1'($urandom_range(0, 1));
            load_addr <= ADDR_W'($urandom);
            load_data <= DATA_W'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        load_addr <= la;
        load_data <= ld;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(f, la, ld);
        sent++;
    endtask

    task automatic step();
        send_item(1'b1, ADDR_W'($urandom), DATA_W'($urandom));
    endtask

    // Place a word at the current program counter, then run it
    task automatic run_word(logic [WORD_W-1:0] w);
        logic [ADDR_W-1:0] p;
        p = sb.pc_q;
        send_item(1'b0, p, w[15:8]);
        send_item(1'b0, p + 12'd1, w[7:0]);
        step();
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        op_t               op;
        logic [DATA_W-1:0] k;
        logic [ADDR_W-1:0] ma;
        logic [ADDR_W-1:0] ja;
        int                r;
        r = $urandom_range(0, 19);
        op = (r < 16) ? op_t'(r[3:0]) : OP_PADD;
        if ($urandom_range(0, 9) == 0)
            case ($urandom_range(0, 2))
                0:       return PRINT_WORD;
                1:       return RESTART_WORD;
                default: return NOP_WORD;
            endcase
        case ($urandom_range(0, 7))
            0:       k = '0;
            1:       k = ACC_ONE;
            2:       k = ACC_ONES;
            3:       k = XOR_KEY;
            default: k = DATA_W'($urandom);
        endcase
        ma = ($urandom_range(0, 3) != 0) ? hot_addr[$urandom_range(0, HOT_COUNT - 1)]
                                         : ADDR_W'($urandom);
        ja = ($urandom_range(0, 19) == 0) ? CLEAR_LAST : ADDR_W'($urandom);
        case (op)
            OP_IMM:
                if ($urandom_range(0, 1))
                    return {op, 4'($urandom_range(SUB_ADD, SUB_AND)), k};
                else
                    return {op, 4'($urandom), k};
            OP_JMP, OP_JZ, OP_JONE, OP_JFF:
                return {op, ja};
            OP_CMPM, OP_LDM, OP_PADD, OP_PDEL, OP_XORK, OP_XORA, OP_ST:
                return {op, ma};
            default:
                return {op, 4'($urandom), k};
        endcase
    endfunction

    initial
    begin
        int idle_plan [4];
        int phase_end;
        sb       = new();
        sent     = 0;
        idle_pct = 0;
        idle_plan = '{0, 68, 0, 10};
        foreach (hot_addr[i])
            hot_addr[i] = ADDR_W'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty memory, wrapped fetch, acc wrap both ways, print,
        // taken jump on all ones, restart and the explicit no-op
        step();
        run_word({OP_JMP, CLEAR_LAST});
        run_word({OP_IMM, SUB_LDI, ACC_ONES});
        run_word({OP_IMM, SUB_ADD, ACC_ONE});
        run_word({OP_IMM, 4'hE, 8'h00});
        run_word(PRINT_WORD);
        run_word({OP_JFF, 12'h123});
        run_word(RESTART_WORD);
        run_word(NOP_WORD);

        foreach (idle_plan[ph])
        begin
            idle_pct  = idle_plan[ph];
            phase_end = sent + ITEM_TARGET / 4;
            while (sent < phase_end)
            begin
                case ($urandom_range(0, 99)) inside
                    [0:7]:   send_item(1'b0, ADDR_W'($urandom), DATA_W'($urandom));
                    [8:14]:  step();
                    default: run_word(pick_word());
                endcase
            end
        end
        start <= 1'b0;

        while (sb.awaited_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0)
            $display("** accumulator_cpu_with_write_protect: PASSED **");
        else
            $display("** accumulator_cpu_with_write_protect: FAILED **");
        $finish;
    end

    // Hard stop well beyond the clearing pass and the slowest legal run
    initial
    begin
        #3_000_000;
        $display("** accumulator_cpu_with_write_protect: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/acp_pkg.sv
src/acp_mem.sv
src/acp_protect.sv
src/accumulator_cpu_with_write_protect.sv
tb/accumulator_cpu_with_write_protect_tb.sv
